/* sv/qedec_pkg.sv */
// shared types and constants of the quadrature encoder decoder
package qedec_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_HALF_STEP = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_MS   = 1'b1;

    localparam logic        HALF_STEP_RESET = 1'b1;
    localparam logic [15:0] HOLD_MS_RESET   = 16'd50;

    // bit i is set when transition code i is a legal gray step
    localparam logic [15:0] VALID_TAB = 16'h6996;

    // detent patterns in the transition history
    localparam logic [7:0]  HALF_LEFT_A  = 8'h2b;
    localparam logic [7:0]  HALF_LEFT_B  = 8'hd4;
    localparam logic [7:0]  HALF_RIGHT_A = 8'h17;
    localparam logic [7:0]  HALF_RIGHT_B = 8'he8;
    localparam logic [15:0] FULL_LEFT    = 16'hd42b;
    localparam logic [15:0] FULL_RIGHT   = 16'he817;

    // item kinds
    localparam logic KIND_PIN  = 1'b0;
    localparam logic KIND_POLL = 1'b1;

    // direction bit stored in the queue
    localparam logic DIR_LEFT  = 1'b0;
    localparam logic DIR_RIGHT = 1'b1;

    typedef enum logic [2:0] {
        PULSE_IDLE  = 3'b001,
        PULSE_LEFT  = 3'b010,
        PULSE_RIGHT = 3'b100
    } pulse_t;

    // queue requests from the decoder
    typedef struct packed {
        logic push;
        logic push_dir;
        logic pop;
    } q_ctrl_t;

    // queue status toward the decoder
    typedef struct packed {
        logic empty;
        logic full;
        logic head_dir;
    } q_stat_t;

    // one result item
    typedef struct packed {
        logic signed [15:0] position;
        logic               left_button;
        logic               right_button;
        logic               overflow_flag;
        logic [15:0]        event_count;
        logic [15:0]        invalid_count;
    } result_t;

endpackage

/* sv/qedec_if.sv */
// item and result channel interfaces of the quadrature encoder decoder
interface qedec_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic        clk_level;
    logic        data_level;
    logic [31:0] now_ms;

    modport source (output valid, kind, clk_level, data_level, now_ms, input ready);
    modport sink   (input valid, kind, clk_level, data_level, now_ms, output ready);
endinterface

interface qedec_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] position;
    logic               left_button;
    logic               right_button;
    logic               overflow_flag;
    logic [15:0]        event_count;
    logic [15:0]        invalid_count;

    modport source (output valid, position, left_button, right_button, overflow_flag,
                    event_count, invalid_count, input ready);
    modport sink   (input valid, position, left_button, right_button, overflow_flag,
                    event_count, invalid_count, output ready);
endinterface

/* sv/qedec_queue.sv */
// direction fifo held in a synchronous memory with a prefetched head
module qedec_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  qedec_pkg::q_ctrl_t ctrl,
    output qedec_pkg::q_stat_t stat
);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;
    logic             head_reg;

    // wrapping pointer increments
    assign wr_ptr_inc = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;

    assign wr_ptr_next = ctrl.push ? wr_ptr_inc : wr_ptr_reg;
    assign rd_ptr_next = ctrl.pop  ? rd_ptr_inc : rd_ptr_reg;

    // pointer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // memory write and registered head read, forwarding a write to the new head
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_ptr_reg] <= ctrl.push_dir;
        end
        if (ctrl.push && (wr_ptr_reg == rd_ptr_next))
        begin
            head_reg <= ctrl.push_dir;
        end
        else
        begin
            head_reg <= mem[rd_ptr_next];
        end
    end

    // status: one slot stays free so full and empty differ
    assign stat.empty    = (wr_ptr_reg == rd_ptr_reg);
    assign stat.full     = (wr_ptr_inc == rd_ptr_reg);
    assign stat.head_dir = head_reg;

endmodule

/* sv/qedec_skid.sv */
// two-entry output buffer that decouples the result channel from the item channel
module qedec_skid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  qedec_pkg::result_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output qedec_pkg::result_t out_data
);
    logic               out_valid_reg;
    logic               skid_valid_reg;
    qedec_pkg::result_t out_data_reg;
    qedec_pkg::result_t skid_data_reg;
    logic               in_fire;
    logic               out_free;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (in_fire)
            begin
                out_data_reg <= in_data;
            end
        end
        else if (in_fire)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* sv/quadrature_encoder_to_button_pulses_core.sv */
// top level: encoder transition decoder, detent queue and button pulse timer
//
//  channel   dir  handshake        payload
//  item      in   valid / ready    kind, clk_level, data_level, now_ms
//  result    out  valid / ready    position, buttons, overflow_flag, counts
//  config    in   cfg_we           cfg_index, cfg_data (no read-back)
//
// every item is decoded in the cycle it is accepted; one item per cycle is
// sustained while ready is high; its result is registered in the output
// buffer. the fifo head is prefetched from memory, so a pop needs no wait.
// a stalled result channel is absorbed by a two-entry output buffer; ready
// drops only when both entries are full. after reset no clearing pass runs.
module quadrature_encoder_to_button_pulses_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [qedec_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [qedec_pkg::CFG_DATA_W-1:0]    cfg_data,
    qedec_item_if.sink                          item,
    qedec_result_if.source                      result
);
    logic               half_step_reg;
    logic [15:0]        hold_ms_reg;
    logic [3:0]         code_reg, code_next;
    logic [15:0]        hist_reg, hist_next;
    logic [15:0]        pos_reg, pos_next;
    logic               dropped_reg, dropped_next;
    qedec_pkg::pulse_t  pulse_reg, pulse_next;
    logic [31:0]        start_reg, start_next;
    logic               left_reg, left_next;
    logic               right_reg, right_next;
    logic [15:0]        change_reg, change_next;
    logic [15:0]        bad_reg, bad_next;

    logic               item_fire;
    logic               skid_ready;
    logic [3:0]         code_new;
    logic [15:0]        hist_new;
    logic               detent_left;
    logic               detent_right;
    logic [31:0]        elapsed;
    logic               holding;
    qedec_pkg::q_ctrl_t q_ctrl;
    qedec_pkg::q_stat_t q_stat;
    qedec_pkg::result_t res_new;
    qedec_pkg::result_t res_out;

    assign item.ready = skid_ready;
    assign item_fire  = item.valid && skid_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_step_reg <= qedec_pkg::HALF_STEP_RESET;
            hold_ms_reg   <= qedec_pkg::HOLD_MS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == qedec_pkg::REG_HALF_STEP)
            begin
                half_step_reg <= cfg_data[0];
            end
            if (cfg_index == qedec_pkg::REG_HOLD_MS)
            begin
                hold_ms_reg <= cfg_data[15:0];
            end
        end
    end

    // transition decode and detent match
    assign code_new = {code_reg[1:0], item.data_level, item.clk_level};
    assign hist_new = {hist_reg[11:0], code_new};

    always_comb
    begin
        detent_left  = 1'b0;
        detent_right = 1'b0;
        if (half_step_reg)
        begin
            detent_left  = (hist_new[7:0] == qedec_pkg::HALF_LEFT_A) ||
                           (hist_new[7:0] == qedec_pkg::HALF_LEFT_B);
            detent_right = (hist_new[7:0] == qedec_pkg::HALF_RIGHT_A) ||
                           (hist_new[7:0] == qedec_pkg::HALF_RIGHT_B);
        end
        else
        begin
            detent_left  = (hist_new == qedec_pkg::FULL_LEFT);
            detent_right = (hist_new == qedec_pkg::FULL_RIGHT);
        end
    end

    // pulse hold timer
    assign elapsed = item.now_ms - start_reg;
    assign holding = (pulse_reg != qedec_pkg::PULSE_IDLE) && (elapsed < {16'd0, hold_ms_reg});

    // item processing
    always_comb
    begin
        code_next      = code_reg;
        hist_next      = hist_reg;
        pos_next       = pos_reg;
        dropped_next   = dropped_reg;
        pulse_next     = pulse_reg;
        start_next     = start_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        change_next    = change_reg;
        bad_next       = bad_reg;
        q_ctrl.push     = 1'b0;
        q_ctrl.push_dir = qedec_pkg::DIR_LEFT;
        q_ctrl.pop      = 1'b0;

        if (item_fire && (item.kind == qedec_pkg::KIND_PIN))
        begin
            code_next   = code_new;
            change_next = change_reg + 16'd1;
            if (!qedec_pkg::VALID_TAB[code_new])
            begin
                bad_next = bad_reg + 16'd1;
            end
            else
            begin
                hist_next = hist_new;
                if (detent_left || detent_right)
                begin
                    pos_next = detent_right ? pos_reg + 16'd1 : pos_reg - 16'd1;
                    if (q_stat.full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        q_ctrl.push     = 1'b1;
                        q_ctrl.push_dir = detent_right ? qedec_pkg::DIR_RIGHT
                                                       : qedec_pkg::DIR_LEFT;
                    end
                end
            end
        end
        else if (item_fire && !holding)
        begin
            case (pulse_reg)
                qedec_pkg::PULSE_IDLE:
                begin
                    if (q_stat.empty)
                    begin
                        if (dropped_reg)
                        begin
                            dropped_next = 1'b0;
                            left_next    = 1'b0;
                            right_next   = 1'b0;
                        end
                    end
                    else
                    begin
                        q_ctrl.pop = 1'b1;
                        start_next = item.now_ms;
                        if (q_stat.head_dir == qedec_pkg::DIR_RIGHT)
                        begin
                            pulse_next = qedec_pkg::PULSE_RIGHT;
                            if (!dropped_reg)
                            begin
                                right_next = 1'b1;
                            end
                        end
                        else
                        begin
                            pulse_next = qedec_pkg::PULSE_LEFT;
                            if (!dropped_reg)
                            begin
                                left_next = 1'b1;
                            end
                        end
                    end
                end
                qedec_pkg::PULSE_RIGHT:
                begin
                    if (!dropped_reg)
                    begin
                        right_next = 1'b0;
                    end
                    pulse_next = qedec_pkg::PULSE_IDLE;
                end
                qedec_pkg::PULSE_LEFT:
                begin
                    if (!dropped_reg)
                    begin
                        left_next = 1'b0;
                    end
                    pulse_next = qedec_pkg::PULSE_IDLE;
                end
                default:
                begin
                    pulse_next = qedec_pkg::PULSE_IDLE;
                end
            endcase
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg    <= '0;
            hist_reg    <= '0;
            pos_reg     <= '0;
            dropped_reg <= 1'b0;
            pulse_reg   <= qedec_pkg::PULSE_IDLE;
            start_reg   <= '0;
            left_reg    <= 1'b0;
            right_reg   <= 1'b0;
            change_reg  <= '0;
            bad_reg     <= '0;
        end
        else
        begin
            code_reg    <= code_next;
            hist_reg    <= hist_next;
            pos_reg     <= pos_next;
            dropped_reg <= dropped_next;
            pulse_reg   <= pulse_next;
            start_reg   <= start_next;
            left_reg    <= left_next;
            right_reg   <= right_next;
            change_reg  <= change_next;
            bad_reg     <= bad_next;
        end
    end

    // direction fifo
    qedec_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (q_ctrl),
        .stat  (q_stat)
    );

    // result snapshot after the item
    assign res_new.position      = pos_next;
    assign res_new.left_button   = left_next;
    assign res_new.right_button  = right_next;
    assign res_new.overflow_flag = dropped_next;
    assign res_new.event_count   = change_next;
    assign res_new.invalid_count = bad_next;

    qedec_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (skid_ready),
        .in_data   (res_new),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (res_out)
    );

    assign result.position      = res_out.position;
    assign result.left_button   = res_out.left_button;
    assign result.right_button  = res_out.right_button;
    assign result.overflow_flag = res_out.overflow_flag;
    assign result.event_count   = res_out.event_count;
    assign result.invalid_count = res_out.invalid_count;

    // checks
    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty at once");

    a_queue_use: assert property (@(posedge clk) disable iff (!rst_n)
        (q_ctrl.push |-> !q_stat.full) and (q_ctrl.pop |-> !q_stat.empty))
        else $error("queue pushed when full or popped when empty");

    a_one_button: assert property (@(posedge clk) disable iff (!rst_n)
        !(left_reg && right_reg))
        else $error("both buttons pressed");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire |=> result.valid)
        else $error("accepted item left no result");

endmodule
